### rtl/p2d_pkg.sv
// shared types and constants of the 2-d polynomial evaluator
// beat structs, q32.32 constants, register index codes; no dependencies
package p2d_pkg;

  localparam int Q_W         = 64;
  localparam int TERMS_W     = 4;
  localparam int SPID_W      = 10;
  localparam int SIDX_W      = 11;
  localparam int COEFF_IDX_W = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TERMS_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERMS_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERT_VALUE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_PERT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPID_BASE  = 3'd4;

  localparam logic [Q_W-1:0] Q_ONE      = 64'h0000_0001_0000_0000;
  localparam logic [Q_W-1:0] Q_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN      = 64'h8000_0000_0000_0000;
  localparam logic [Q_W-1:0] PERT_RESET = 64'd4295;

  typedef struct packed {
    logic                          req_type;
    logic [COEFF_IDX_W-1:0]        coeff_index;
    logic signed [Q_W-1:0]         coeff_value;
    logic                          solvable;
    logic                          want_perturbed;
    logic signed [Q_W-1:0]         x_coord;
    logic signed [Q_W-1:0]         y_coord;
  } in_beat_t;

  typedef struct packed {
    logic signed [Q_W-1:0]         poly_value;
    logic                          has_perturbed;
    logic [SIDX_W-1:0]             solver_index;
    logic signed [Q_W-1:0]         perturbed_value;
    logic signed [Q_W-1:0]         perturbation;
    logic                          last;
  } out_beat_t;

endpackage

### rtl/p2d_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module p2d_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/p2d_mul.sv
// multi-cycle q32.32 multiplier: four 32x32 partial products, round, saturate
// depends on p2d_pkg
module p2d_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [p2d_pkg::Q_W-1:0]   a,
  input  logic [p2d_pkg::Q_W-1:0]   b,
  output logic                      done,
  output logic [p2d_pkg::Q_W-1:0]   res
);

  localparam int QW    = p2d_pkg::Q_W;
  localparam int HALF  = QW / 2;
  localparam int ACC_W = 2 * QW;
  localparam logic [ACC_W-1:0] RND     = ACC_W'(1) << (HALF - 1);
  localparam logic [ACC_W-1:0] RND_NEG = RND + ACC_W'(1);
  localparam logic [2:0] STEP_ROUND = 3'd4;
  localparam logic [2:0] STEP_SAT   = 3'd5;

  logic [2:0]       step_r;
  logic             busy_r;
  logic             done_r;
  logic             neg_r;
  logic [QW-1:0]    ma_r;
  logic [QW-1:0]    mb_r;
  logic [ACC_W-1:0] acc_r;
  logic [QW-1:0]    res_r;

  logic [HALF-1:0]  pa;
  logic [HALF-1:0]  pb;
  logic [QW-1:0]    pp;
  logic [ACC_W-1:0] pp_sh;
  logic [QW-1:0]    ma;
  logic [QW-1:0]    mb;
  logic [QW-1:0]    sat;
  logic [QW-HALF:0] top;

  assign ma = a[QW-1] ? (~a + 1'b1) : a;
  assign mb = b[QW-1] ? (~b + 1'b1) : b;

  // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  assign pa = step_r[1] ? ma_r[QW-1:HALF] : ma_r[HALF-1:0];
  assign pb = step_r[0] ? mb_r[QW-1:HALF] : mb_r[HALF-1:0];
  assign pp = QW'(pa) * QW'(pb);

  always_comb begin
    if (step_r[1:0] == 2'd0) begin
      pp_sh = ACC_W'(pp);
    end else if (step_r[1:0] == 2'd3) begin
      pp_sh = ACC_W'(pp) << QW;
    end else begin
      pp_sh = ACC_W'(pp) << HALF;
    end
  end

  assign top = acc_r[ACC_W-1:QW+HALF-1];

  always_comb begin
    if ((top == '0) || (top == '1)) begin
      sat = acc_r[QW+HALF-1:HALF];
    end else if (acc_r[ACC_W-1]) begin
      sat = p2d_pkg::Q_MIN;
    end else begin
      sat = p2d_pkg::Q_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == STEP_SAT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      neg_r <= a[QW-1] ^ b[QW-1];
      ma_r  <= ma;
      mb_r  <= mb;
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r == STEP_ROUND) begin
        acc_r <= neg_r ? (~acc_r + RND_NEG) : (acc_r + RND);
      end else if (step_r == STEP_SAT) begin
        res_r <= sat;
      end else begin
        acc_r <= acc_r + pp_sh;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### rtl/poly2d_eval_with_perturbation_top.sv
// top level of the 2-d polynomial evaluator with perturbed results
// sequencer, config registers, solvable bits; uses p2d_pkg, p2d_ram, p2d_mul
//
//  channel  ports                           direction  handshake
//  input    start, busy, in_beat            in         beat taken when start & !busy
//  result   out_strobe, out_beat            out        one-cycle strobe per beat, no stall
//  config   cfg_we, cfg_index, cfg_data     in         write when cfg_we, no wait
//
// one item at a time; busy stays high until the item's last beat is out
// each q32.32 product goes through the shared multiplier, which sets the rate
// load: written when taken; a perturbation scaled by the coefficient waits for its product
// evaluate: a horner product per coefficient plus products per row, plus a scan
//   to count solvable slots and products per perturbed beat when asked for
// reset is synchronous: control and config registers to reset values, all solvable bits cleared
// results cannot be held off by the receiver
module poly2d_eval_with_perturbation_top #(
  parameter int MAX_TERMS_X = 8,
  parameter int MAX_TERMS_Y = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  p2d_pkg::in_beat_t                       in_beat,
  output logic                                    out_strobe,
  output p2d_pkg::out_beat_t                      out_beat,
  input  logic                                    cfg_we,
  input  logic [p2d_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [p2d_pkg::CFG_DATA_W-1:0]          cfg_data
);

  localparam int QW     = p2d_pkg::Q_W;
  localparam int TW     = p2d_pkg::TERMS_W;
  localparam int SW     = p2d_pkg::SIDX_W;
  localparam int SLOTS  = MAX_TERMS_X * MAX_TERMS_Y;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int N_W    = 2 * TW;
  localparam int IDXC_W = p2d_pkg::COEFF_IDX_W + 1;

  // sequencer states
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_LMUL   = 5'd1;
  localparam logic [4:0] ST_CNT    = 5'd2;
  localparam logic [4:0] ST_EVS    = 5'd3;
  localparam logic [4:0] ST_HRD    = 5'd4;
  localparam logic [4:0] ST_HMUL   = 5'd5;
  localparam logic [4:0] ST_HEND   = 5'd6;
  localparam logic [4:0] ST_ROWMUL = 5'd7;
  localparam logic [4:0] ST_PYMUL  = 5'd8;
  localparam logic [4:0] ST_FIN    = 5'd9;
  localparam logic [4:0] ST_PSCAN  = 5'd10;
  localparam logic [4:0] ST_PRD    = 5'd11;
  localparam logic [4:0] ST_PM1    = 5'd12;
  localparam logic [4:0] ST_PM2    = 5'd13;
  localparam logic [4:0] ST_PADV   = 5'd14;
  localparam logic [4:0] ST_PXM    = 5'd15;
  localparam logic [4:0] ST_PPY    = 5'd16;

  // saturating q32.32 add
  function automatic logic [QW-1:0] q_add(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [QW-1:0] s;
    s = a + b;
    if ((a[QW-1] == b[QW-1]) && (s[QW-1] != a[QW-1])) begin
      s = a[QW-1] ? p2d_pkg::Q_MIN : p2d_pkg::Q_MAX;
    end
    return s;
  endfunction

  // term counts are clamped to 1..max when used
  function automatic logic [TW-1:0] clamp_terms(input logic [TW-1:0] v, input logic [TW-1:0] mx);
    logic [TW-1:0] r;
    r = v;
    if (v == '0) begin
      r = TW'(1);
    end else if (v > mx) begin
      r = mx;
    end
    return r;
  endfunction

  // config registers
  logic [TW-1:0]                 terms_x_r;
  logic [TW-1:0]                 terms_y_r;
  logic [QW-1:0]                 pert_value_r;
  logic                          rel_pert_r;
  logic [p2d_pkg::SPID_W-1:0]    spid_base_r;

  // sequencer state
  logic [4:0]        state_r,  state_nxt;
  logic [SLOTS-1:0]  mask_r;
  logic [QW-1:0]     x_r,      x_nxt;
  logic [QW-1:0]     y_r,      y_nxt;
  logic              want_r,   want_nxt;
  logic [QW-1:0]     hv_r,     hv_nxt;
  logic [QW-1:0]     t_r,      t_nxt;
  logic [QW-1:0]     total_r,  total_nxt;
  logic [QW-1:0]     powy_r,   powy_nxt;
  logic [QW-1:0]     px_r,     px_nxt;
  logic [TW-1:0]     hcnt_r,   hcnt_nxt;
  logic [SLOT_W-1:0] haddr_r,  haddr_nxt;
  logic [SLOT_W-1:0] base_r,   base_nxt;
  logic [SLOT_W-1:0] pidx_r,   pidx_nxt;
  logic [TW-1:0]     ix_r,     ix_nxt;
  logic [TW-1:0]     iy_r,     iy_nxt;
  logic [CNT_W-1:0]  kc_r,     kc_nxt;
  logic [CNT_W-1:0]  nsolv_r,  nsolv_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  p2d_pkg::out_beat_t     out_beat_r,   out_beat_nxt;

  // derived values
  logic              accept;
  logic              is_load;
  logic              idx_ok;
  logic [SLOT_W-1:0] idx_slot;
  logic [TW-1:0]     tx;
  logic [TW-1:0]     ty;
  logic              tx1;
  logic [N_W-1:0]    n_act;
  logic [SLOT_W-1:0] k_addr;
  logic [SLOT_W-1:0] base_step;
  logic              last_beat;
  logic [QW-1:0]     tsum;

  // memory and multiplier hookup
  logic              c_we;
  logic              c_re;
  logic [SLOT_W-1:0] c_raddr;
  logic [QW-1:0]     c_rd;
  logic              p_we;
  logic              p_re;
  logic [SLOT_W-1:0] p_waddr;
  logic [QW-1:0]     p_wdata;
  logic [QW-1:0]     p_rd;
  logic              mul_start;
  logic [QW-1:0]     mul_a;
  logic [QW-1:0]     mul_b;
  logic              mul_done;
  logic [QW-1:0]     mul_res;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign is_load  = !in_beat.req_type;
  assign idx_ok   = IDXC_W'(in_beat.coeff_index) < IDXC_W'(SLOTS);
  assign idx_slot = in_beat.coeff_index[SLOT_W-1:0];

  assign tx    = clamp_terms(terms_x_r, TW'(MAX_TERMS_X));
  assign ty    = clamp_terms(terms_y_r, TW'(MAX_TERMS_Y));
  assign tx1   = (tx == TW'(1));
  assign n_act = N_W'(tx) * N_W'(ty);

  assign k_addr    = SLOT_W'(base_r + ix_r);
  assign base_step = SLOT_W'(base_r + tx);
  assign last_beat = (CNT_W'(cnt_r + 1'b1) == nsolv_r);
  assign tsum      = q_add(mul_res, c_rd);

  p2d_ram #(.WIDTH(QW), .DEPTH(SLOTS)) u_coeff_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (idx_slot),
    .wdata (in_beat.coeff_value),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rd)
  );

  p2d_ram #(.WIDTH(QW), .DEPTH(SLOTS)) u_pert_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (k_addr),
    .rdata (p_rd)
  );

  p2d_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    want_nxt       = want_r;
    hv_nxt         = hv_r;
    t_nxt          = t_r;
    total_nxt      = total_r;
    powy_nxt       = powy_r;
    px_nxt         = px_r;
    hcnt_nxt       = hcnt_r;
    haddr_nxt      = haddr_r;
    base_nxt       = base_r;
    pidx_nxt       = pidx_r;
    ix_nxt         = ix_r;
    iy_nxt         = iy_r;
    kc_nxt         = kc_r;
    nsolv_nxt      = nsolv_r;
    cnt_nxt        = cnt_r;
    out_strobe_nxt = 1'b0;
    out_beat_nxt   = out_beat_r;
    mul_start      = 1'b0;
    mul_a          = t_r;
    mul_b          = hv_r;
    c_we           = 1'b0;
    c_re           = 1'b0;
    c_raddr        = SLOT_W'(haddr_r - 1'b1);
    p_we           = 1'b0;
    p_re           = 1'b0;
    p_waddr        = idx_slot;
    p_wdata        = pert_value_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_load) begin
            if (idx_ok) begin
              c_we = 1'b1;
              // relative perturbation of a nonzero coefficient needs a product
              if (rel_pert_r && (in_beat.coeff_value != '0)) begin
                mul_start = 1'b1;
                mul_a     = pert_value_r;
                mul_b     = in_beat.coeff_value;
                pidx_nxt  = idx_slot;
                state_nxt = ST_LMUL;
              end else begin
                p_we = 1'b1;
              end
            end
          end else begin
            x_nxt     = in_beat.x_coord;
            y_nxt     = in_beat.y_coord;
            want_nxt  = in_beat.want_perturbed;
            kc_nxt    = '0;
            nsolv_nxt = '0;
            state_nxt = in_beat.want_perturbed ? ST_CNT : ST_EVS;
          end
        end
      end
      ST_LMUL: begin
        p_waddr = pidx_r;
        p_wdata = mul_res;
        if (mul_done) begin
          p_we      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CNT: begin
        // one solvable bit per cycle over the active slots
        if (N_W'(kc_r) < n_act) begin
          if (mask_r[kc_r[SLOT_W-1:0]]) begin
            nsolv_nxt = CNT_W'(nsolv_r + 1'b1);
          end
          kc_nxt = CNT_W'(kc_r + 1'b1);
        end else begin
          state_nxt = ST_EVS;
        end
      end
      ST_EVS: begin
        // one column: horner in y over slots 0..ty-1; else row 0 horner in x
        total_nxt = '0;
        powy_nxt  = p2d_pkg::Q_ONE;
        iy_nxt    = '0;
        base_nxt  = '0;
        hv_nxt    = tx1 ? y_r : x_r;
        hcnt_nxt  = tx1 ? TW'(ty - 1'b1) : TW'(tx - 1'b1);
        haddr_nxt = tx1 ? SLOT_W'(ty - 1'b1) : SLOT_W'(tx - 1'b1);
        c_re      = 1'b1;
        c_raddr   = haddr_nxt;
        state_nxt = ST_HRD;
      end
      ST_HRD: begin
        t_nxt = c_rd;
        if (hcnt_r == '0) begin
          state_nxt = ST_HEND;
        end else begin
          mul_start = 1'b1;
          mul_a     = c_rd;
          c_re      = 1'b1;
          haddr_nxt = SLOT_W'(haddr_r - 1'b1);
          state_nxt = ST_HMUL;
        end
      end
      ST_HMUL: begin
        if (mul_done) begin
          t_nxt    = tsum;
          hcnt_nxt = TW'(hcnt_r - 1'b1);
          if (hcnt_r == TW'(1)) begin
            state_nxt = ST_HEND;
          end else begin
            mul_start = 1'b1;
            mul_a     = tsum;
            c_re      = 1'b1;
            haddr_nxt = SLOT_W'(haddr_r - 1'b1);
          end
        end
      end
      ST_HEND: begin
        if (tx1) begin
          total_nxt = t_r;
          state_nxt = ST_FIN;
        end else begin
          mul_start = 1'b1;
          mul_a     = t_r;
          mul_b     = powy_r;
          state_nxt = ST_ROWMUL;
        end
      end
      ST_ROWMUL: begin
        if (mul_done) begin
          total_nxt = q_add(total_r, mul_res);
          if (TW'(iy_r + 1'b1) == ty) begin
            state_nxt = ST_FIN;
          end else begin
            mul_start = 1'b1;
            mul_a     = powy_r;
            mul_b     = y_r;
            state_nxt = ST_PYMUL;
          end
        end
      end
      ST_PYMUL: begin
        if (mul_done) begin
          powy_nxt  = mul_res;
          iy_nxt    = TW'(iy_r + 1'b1);
          base_nxt  = base_step;
          hcnt_nxt  = TW'(tx - 1'b1);
          haddr_nxt = SLOT_W'(base_step + tx - 1'b1);
          c_re      = 1'b1;
          c_raddr   = haddr_nxt;
          state_nxt = ST_HRD;
        end
      end
      ST_FIN: begin
        if (want_r && (nsolv_r != '0)) begin
          ix_nxt    = '0;
          iy_nxt    = '0;
          base_nxt  = '0;
          px_nxt    = p2d_pkg::Q_ONE;
          powy_nxt  = p2d_pkg::Q_ONE;
          cnt_nxt   = '0;
          state_nxt = ST_PSCAN;
        end else begin
          out_strobe_nxt               = 1'b1;
          out_beat_nxt.poly_value      = total_r;
          out_beat_nxt.has_perturbed   = 1'b0;
          out_beat_nxt.solver_index    = '0;
          out_beat_nxt.perturbed_value = '0;
          out_beat_nxt.perturbation    = '0;
          out_beat_nxt.last            = 1'b1;
          state_nxt                    = ST_IDLE;
        end
      end
      ST_PSCAN: begin
        if (mask_r[k_addr]) begin
          p_re      = 1'b1;
          state_nxt = ST_PRD;
        end else begin
          state_nxt = ST_PADV;
        end
      end
      ST_PRD: begin
        mul_start = 1'b1;
        mul_a     = p_rd;
        mul_b     = px_r;
        state_nxt = ST_PM1;
      end
      ST_PM1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_res;
          mul_b     = powy_r;
          state_nxt = ST_PM2;
        end
      end
      ST_PM2: begin
        if (mul_done) begin
          out_strobe_nxt               = 1'b1;
          out_beat_nxt.poly_value      = total_r;
          out_beat_nxt.has_perturbed   = 1'b1;
          out_beat_nxt.solver_index    = SW'(spid_base_r) + SW'(cnt_r);
          out_beat_nxt.perturbed_value = q_add(total_r, mul_res);
          out_beat_nxt.perturbation    = p_rd;
          out_beat_nxt.last            = last_beat;
          cnt_nxt                      = CNT_W'(cnt_r + 1'b1);
          state_nxt                    = last_beat ? ST_IDLE : ST_PADV;
        end
      end
      ST_PADV: begin
        // next slot along x, else next row, else done
        if ((TW + 1)'(ix_r) + 1'b1 < (TW + 1)'(tx)) begin
          mul_start = 1'b1;
          mul_a     = px_r;
          mul_b     = x_r;
          state_nxt = ST_PXM;
        end else if ((TW + 1)'(iy_r) + 1'b1 < (TW + 1)'(ty)) begin
          mul_start = 1'b1;
          mul_a     = powy_r;
          mul_b     = y_r;
          state_nxt = ST_PPY;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PXM: begin
        if (mul_done) begin
          px_nxt    = mul_res;
          ix_nxt    = TW'(ix_r + 1'b1);
          state_nxt = ST_PSCAN;
        end
      end
      ST_PPY: begin
        if (mul_done) begin
          powy_nxt  = mul_res;
          iy_nxt    = TW'(iy_r + 1'b1);
          ix_nxt    = '0;
          px_nxt    = p2d_pkg::Q_ONE;
          base_nxt  = base_step;
          state_nxt = ST_PSCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      mask_r       <= '0;
      terms_x_r    <= TW'(1);
      terms_y_r    <= TW'(1);
      pert_value_r <= p2d_pkg::PERT_RESET;
      rel_pert_r   <= 1'b1;
      spid_base_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (accept && is_load && idx_ok) begin
        mask_r[idx_slot] <= in_beat.solvable;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          p2d_pkg::CFG_TERMS_X:    terms_x_r    <= cfg_data[TW-1:0];
          p2d_pkg::CFG_TERMS_Y:    terms_y_r    <= cfg_data[TW-1:0];
          p2d_pkg::CFG_PERT_VALUE: pert_value_r <= cfg_data[QW-1:0];
          p2d_pkg::CFG_REL_PERT:   rel_pert_r   <= cfg_data[0];
          p2d_pkg::CFG_SPID_BASE:  spid_base_r  <= cfg_data[p2d_pkg::SPID_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    want_r     <= want_nxt;
    hv_r       <= hv_nxt;
    t_r        <= t_nxt;
    total_r    <= total_nxt;
    powy_r     <= powy_nxt;
    px_r       <= px_nxt;
    hcnt_r     <= hcnt_nxt;
    haddr_r    <= haddr_nxt;
    base_r     <= base_nxt;
    pidx_r     <= pidx_nxt;
    ix_r       <= ix_nxt;
    iy_r       <= iy_nxt;
    kc_r       <= kc_nxt;
    nsolv_r    <= nsolv_nxt;
    cnt_r      <= cnt_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_beat   = out_beat_r;

endmodule
